FILE: design/itfsr_pkg.sv
// ----------------------------------------------------------------------------
// itfsr_pkg: shared types and constants
// Word kinds, queue entry layout, frame constants and status codes for the
// idle-framed time-set receiver.
// ----------------------------------------------------------------------------
package itfsr_pkg;

  localparam int unsigned STORE_DEPTH_DEF = 16;
  localparam int unsigned FRAME_BYTES     = 8;
  localparam int unsigned SLOT_W          = $clog2(FRAME_BYTES);
  localparam int unsigned QUEUE_DEPTH     = 2;
  localparam int unsigned TIME_BYTES      = 5;
  localparam int unsigned OUT_DATA_W      = 8 * TIME_BYTES;

  localparam logic [7:0] HEADER_BYTE = 8'h5A;
  localparam logic [7:0] LENGTH_BYTE = 8'h06;

  localparam int unsigned SUM_BYTES  = 7;
  localparam int unsigned CHECK_SLOT = 7;
  localparam int unsigned HDR_SLOT   = 0;
  localparam int unsigned LEN_SLOT   = 1;
  localparam int unsigned TIME_SLOT  = 2;

  typedef enum logic {
    KIND_DATA = 1'b0,
    KIND_IDLE = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CHECKSUM = 2'd1,
    ST_HEADER   = 2'd2,
    ST_LENGTH   = 2'd3
  } status_t;

  typedef struct packed {
    kind_t             kind;
    logic              in_frame;
    logic [SLOT_W-1:0] slot;
    logic [7:0]        data;
  } entry_t;

endpackage

FILE: design/itfsr_front.sv
// ----------------------------------------------------------------------------
// itfsr_front: input stage
// Accepts words, tracks the wrapping write position and classifies each word
// into a queue entry for the back end.
// ----------------------------------------------------------------------------
module itfsr_front import itfsr_pkg::*; #(
  parameter int unsigned STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] rx_byte
  input  logic       in_tuser,   // [0] mode
  input  logic       q_full,
  output logic       q_push,
  output entry_t     q_entry
);

  localparam int unsigned POS_W = $clog2(STORE_DEPTH);

  logic [POS_W-1:0] pos_r, pos_nxt;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && in_tready;

  always_comb begin
    q_entry.kind     = kind_t'(in_tuser);
    q_entry.in_frame = ({1'b0, pos_r} < (POS_W+1)'(FRAME_BYTES));
    q_entry.slot     = pos_r[SLOT_W-1:0];
    q_entry.data     = in_tdata;
  end

  always_comb begin
    pos_nxt = pos_r;
    if (q_push) begin
      if (kind_t'(in_tuser) == KIND_IDLE) begin
        pos_nxt = '0;
      end else if (pos_r == POS_W'(STORE_DEPTH - 1)) begin
        pos_nxt = '0;
      end else begin
        pos_nxt = pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

FILE: design/itfsr_queue.sv
// ----------------------------------------------------------------------------
// itfsr_queue: decoupling queue
// Short FIFO of classified entries between the front and back ends.
// ----------------------------------------------------------------------------
module itfsr_queue import itfsr_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   q_valid,
  output entry_t q_entry
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wptr_r, wptr_nxt;
  logic [PTR_W-1:0]   rptr_r, rptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_entry = mem_r[rptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_entry;
    end
  end

endmodule

FILE: design/itfsr_back.sv
// ----------------------------------------------------------------------------
// itfsr_back: frame execution
// Holds the frame bytes, writes in-frame data words, and on an idle word
// checks the frame, loads the result register and clears the frame.
// ----------------------------------------------------------------------------
module itfsr_back import itfsr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  entry_t                q_entry,
  output logic                  q_pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // year, month, day, hour, minute
  output logic [1:0]            out_tuser   // [1:0] status
);

  logic [7:0]            byte_r [FRAME_BYTES];
  logic                  ovld_r, ovld_nxt;
  status_t               ost_r;
  logic [OUT_DATA_W-1:0] odata_r;
  logic [7:0]            sum;
  status_t               st;
  logic [OUT_DATA_W-1:0] tdata_c;
  logic                  is_idle, pop_idle, pop_data;

  assign is_idle  = (q_entry.kind == KIND_IDLE);
  assign q_pop    = q_valid && (!is_idle || !ovld_r || out_tready);
  assign pop_idle = q_pop && is_idle;
  assign pop_data = q_pop && !is_idle;

  always_comb begin
    sum = '0;
    for (int i = 0; i < SUM_BYTES; i++) begin
      sum = sum + byte_r[i];
    end
    if (sum != byte_r[CHECK_SLOT]) begin
      st = ST_CHECKSUM;
    end else if (byte_r[HDR_SLOT] != HEADER_BYTE) begin
      st = ST_HEADER;
    end else if (byte_r[LEN_SLOT] != LENGTH_BYTE) begin
      st = ST_LENGTH;
    end else begin
      st = ST_OK;
    end
    for (int k = 0; k < TIME_BYTES; k++) begin
      tdata_c[8*k +: 8] = (st == ST_OK) ? byte_r[TIME_SLOT + k] : 8'h00;
    end
  end

  always_comb begin
    ovld_nxt = ovld_r;
    if (out_tready) begin
      ovld_nxt = 1'b0;
    end
    if (pop_idle) begin
      ovld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
      for (int i = 0; i < FRAME_BYTES; i++) begin
        byte_r[i] <= '0;
      end
    end else begin
      ovld_r <= ovld_nxt;
      if (pop_idle) begin
        for (int i = 0; i < FRAME_BYTES; i++) begin
          byte_r[i] <= '0;
        end
      end else if (pop_data && q_entry.in_frame) begin
        byte_r[q_entry.slot] <= q_entry.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_idle) begin
      ost_r   <= st;
      odata_r <= tdata_c;
    end
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ost_r;

  a_clear_after_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop_idle |=> (byte_r[HDR_SLOT] == '0 && byte_r[CHECK_SLOT] == '0))
    else $error("frame not cleared after idle word");

  a_result_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (ovld_r && !$past(ovld_r)) |-> $past(pop_idle))
    else $error("result appeared without idle word");

  a_fail_zero_time: assert property (@(posedge clk) disable iff (!rst_n)
    (ovld_r && ost_r != ST_OK) |-> (odata_r == '0))
    else $error("time fields not zero on failed frame");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (ovld_r && !out_tready) |-> !pop_idle)
    else $error("pending result overwritten");

endmodule

FILE: design/idle_framed_time_set_receiver.sv
// ----------------------------------------------------------------------------
// idle_framed_time_set_receiver: top level
// Path: an idle word is written into the queue at acceptance, then the back
// end pops it and loads the result register.
// Throughput: one word per cycle; a held result stalls the next idle word,
// and the input once the two-entry queue fills up behind it.
// Reset: synchronous active-low rst_n clears position, queue, frame and result valid.
// ----------------------------------------------------------------------------
module idle_framed_time_set_receiver import itfsr_pkg::*; #(
  parameter int unsigned STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] rx_byte
  input  logic                  in_tuser,   // [0] mode
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [7:0] year_since_2000,
                                            // [15:8] month_number,
                                            // [23:16] day_of_month,
                                            // [31:24] hour_value,
                                            // [39:32] minute_value
  output logic [1:0]            out_tuser   // [1:0] status
);

  logic   push, full, pop, q_valid;
  entry_t push_entry, q_entry;

  itfsr_front #(.STORE_DEPTH(STORE_DEPTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (full),
    .q_push    (push),
    .q_entry   (push_entry)
  );

  itfsr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .q_valid    (q_valid),
    .q_entry    (q_entry)
  );

  itfsr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .q_pop      (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
